// ===== hdl/sfd_pkg.sv =====
package sfd_pkg;

    localparam int PAYLOAD_DEPTH = 64;
    localparam int PAYLOAD_AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    localparam logic [7:0] START_FLAG = 8'h7E;

    localparam logic [6:0] POS_HDR_END = 7'd3;
    localparam logic [6:0] POS_MAX     = 7'd127;

    typedef logic [7:0] t_byte;
    typedef logic [5:0] t_size;
    typedef logic [3:0] t_seq;
    typedef logic [5:0] t_type;
    typedef logic [6:0] t_pos;
    typedef logic [1:0] t_kind;

    localparam t_kind KIND_PAYLOAD = 2'd0;
    localparam t_kind KIND_HEADER  = 2'd1;
    localparam t_kind KIND_NACK    = 2'd2;

    typedef struct packed {
        t_kind item_kind;
        t_byte payload_byte;
        t_size frame_size;
        t_seq  frame_sequence;
        t_type frame_type;
        logic  run_last;
    } t_out_item;

    typedef struct packed {
        logic rx_take;
        logic idx_clr;
        logic rd_issue;
        logic load_pay;
        logic load_hdr;
        logic load_nack;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic parity_byte;
        logic parity_ok;
        logic size_zero;
        logic last_idx;
    } t_sts;

endpackage

// ===== hdl/sfd_if.sv =====
interface sfd_in_if;
    import sfd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;
    logic  buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface sfd_out_if;
    import sfd_pkg::*;

    logic  valid;
    logic  ready;
    t_kind item_kind;
    t_byte payload_byte;
    t_size frame_size;
    t_seq  frame_sequence;
    t_type frame_type;
    logic  run_last;

    modport source (output valid, output item_kind, output payload_byte, output frame_size,
                    output frame_sequence, output frame_type, output run_last, input ready);
    modport sink   (input valid, input item_kind, input payload_byte, input frame_size,
                    input frame_sequence, input frame_type, input run_last, output ready);
endinterface

// ===== hdl/sfd_ram.sv =====
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/sfd_datapath.sv =====
module sfd_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfd_pkg::t_byte     i_rx_byte,
    input  logic               i_buffer_end,
    input  sfd_pkg::t_cmd      i_cmd,
    output sfd_pkg::t_sts      o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output sfd_pkg::t_out_item o_out_item
);
    import sfd_pkg::*;

    t_pos      r_pos, n_pos;
    logic      r_disc, n_disc;
    t_size     r_size, n_size;
    t_seq      r_seq, n_seq;
    t_type     r_type, n_type;
    t_byte     r_xor, n_xor;
    t_size     r_rd_idx, n_rd_idx;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    t_pos      payload_end;
    t_pos      wr_idx;
    logic      in_payload;
    logic      is_parity;
    logic      wr_en;
    t_byte     rd_data;

    assign payload_end = POS_HDR_END + {1'b0, r_size};
    assign wr_idx      = r_pos - POS_HDR_END;
    assign in_payload  = !r_disc && (r_pos >= POS_HDR_END) && (r_pos < payload_end);
    assign is_parity   = !r_disc && (r_pos >= POS_HDR_END) && (r_pos >= payload_end);
    assign wr_en       = i_cmd.rx_take && in_payload;

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx[PAYLOAD_AW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_rd_idx[PAYLOAD_AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_pos  = r_pos;
        n_disc = r_disc;
        n_size = r_size;
        n_seq  = r_seq;
        n_type = r_type;
        n_xor  = r_xor;
        if (i_cmd.rx_take) begin
            if (!r_disc) begin
                if (r_pos == 7'd0) begin
                    if (i_rx_byte != START_FLAG) begin
                        n_disc = 1'b1;
                    end
                end else if (r_pos == 7'd1) begin
                    n_size = i_rx_byte[5:0];
                    n_seq  = {2'b00, i_rx_byte[7:6]};
                end else if (r_pos == 7'd2) begin
                    n_seq  = {i_rx_byte[1:0], r_seq[1:0]};
                    n_type = i_rx_byte[7:2];
                    if ({1'b0, r_size} > 7'(PAYLOAD_DEPTH)) begin
                        n_disc = 1'b1;
                    end
                end else if (in_payload) begin
                    n_xor = r_xor ^ i_rx_byte;
                end else begin
                    n_disc = 1'b1;
                end
                if (!n_disc && r_pos < POS_MAX) begin
                    n_pos = r_pos + 7'd1;
                end
            end
            if (i_buffer_end) begin
                n_pos  = '0;
                n_disc = 1'b0;
                n_xor  = '0;
            end
        end
    end

    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.idx_clr) begin
            n_rd_idx = '0;
        end else if (i_cmd.load_pay) begin
            n_rd_idx = r_rd_idx + 6'd1;
        end
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.load_pay) begin
            n_out       = '{KIND_PAYLOAD, rd_data, r_size, r_seq, r_type, 1'b0};
            n_out_valid = 1'b1;
        end else if (i_cmd.load_hdr) begin
            n_out       = '{KIND_HEADER, 8'd0, r_size, r_seq, r_type, 1'b1};
            n_out_valid = 1'b1;
        end else if (i_cmd.load_nack) begin
            n_out       = '{KIND_NACK, 8'd0, 6'd0, 4'd0, 6'd0, 1'b1};
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_disc      <= 1'b0;
            r_size      <= '0;
            r_seq       <= '0;
            r_type      <= '0;
            r_xor       <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_disc      <= n_disc;
            r_size      <= n_size;
            r_seq       <= n_seq;
            r_type      <= n_type;
            r_xor       <= n_xor;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_sts.parity_byte = is_parity;
    assign o_sts.parity_ok   = (i_rx_byte == r_xor);
    assign o_sts.size_zero   = (r_size == 6'd0);
    assign o_sts.last_idx    = ({1'b0, r_rd_idx} + 7'd1) == {1'b0, r_size};

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hdl/sfd_ctrl.sv =====
module sfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sfd_pkg::t_sts i_sts,
    output sfd_pkg::t_cmd o_cmd
);
    import sfd_pkg::*;

    localparam logic [1:0] ST_RX  = 2'd0;
    localparam logic [1:0] ST_RD  = 2'd1;
    localparam logic [1:0] ST_LD  = 2'd2;
    localparam logic [1:0] ST_HDR = 2'd3;

    logic [1:0] r_state, n_state;
    logic       in_fire;

    // only the parity byte loads a result, so only it waits for room
    assign o_in_ready = (r_state == ST_RX) && (i_sts.out_free || !i_sts.parity_byte);
    assign in_fire    = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rx_take = in_fire;
        unique case (r_state)
            ST_RX: begin
                if (in_fire && i_sts.parity_byte) begin
                    if (i_sts.parity_ok) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = i_sts.size_zero ? ST_HDR : ST_RD;
                    end else begin
                        o_cmd.load_nack = 1'b1;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = ST_LD;
            end
            ST_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_pay = 1'b1;
                    n_state = i_sts.last_idx ? ST_HDR : ST_RD;
                end
            end
            ST_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_hdr = 1'b1;
                    n_state = ST_RX;
                end
            end
            default: n_state = ST_RX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RX;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_reset_state: assert property (@(posedge i_clk) !i_rst_n |=> r_state == ST_RX)
        else $error("controller not in receive state after reset");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_pay || o_cmd.load_hdr || o_cmd.load_nack) |-> i_sts.out_free)
        else $error("result loaded while output register still full");

    a_good_parity_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_sts.parity_byte && i_sts.parity_ok) |=>
        (r_state == ST_RD || r_state == ST_HDR))
        else $error("matching parity did not start release");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |=> (r_state == ST_LD))
        else $error("store read not followed by load state");
`endif

endmodule

// ===== hdl/start_flag_packet_deframer_top.sv =====
// channel | dir | handshake          | payload
// i_in    | in  | valid/ready        | rx_byte[7:0], buffer_end
// o_out   | out | valid/ready        | item_kind[1:0], payload_byte[7:0], frame_size[5:0],
//         |     |                    | frame_sequence[3:0], frame_type[5:0], run_last
//
// One byte per cycle while receiving; the output register lets a byte in while the
// previous result waits to be taken, except a parity byte, which waits for room.
// A good parity byte releases N payload items, each by a store read and then a
// load, and then the header item; no input is taken during the release.
// Synchronous active-low reset; the payload store is not cleared.
// Output stalls hold the result register, hold back a parity request on i_in and
// stretch the release.
module start_flag_packet_deframer_top (
    input logic       i_clk,
    input logic       i_rst_n,
    sfd_in_if.sink    i_in,
    sfd_out_if.source o_out
);
    import sfd_pkg::*;

    t_cmd      cmd;
    t_sts      sts;
    t_out_item out_item;
    logic      out_valid;
    logic      in_ready;

    sfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sfd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_byte    (i_in.rx_byte),
        .i_buffer_end (i_in.buffer_end),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (out_valid),
        .o_out_item   (out_item)
    );

    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.item_kind      = out_item.item_kind;
    assign o_out.payload_byte   = out_item.payload_byte;
    assign o_out.frame_size     = out_item.frame_size;
    assign o_out.frame_sequence = out_item.frame_sequence;
    assign o_out.frame_type     = out_item.frame_type;
    assign o_out.run_last       = out_item.run_last;

endmodule
